// ===== rtl/htc_pkg.sv =====
// Package for the humidity/temperature compensation block.
// Field widths, conversion constants and reciprocal factors. No dependencies.
package htc_pkg;

    localparam int TEMP_RAW_W = 14;
    localparam int HUM_RAW_W  = 12;
    localparam int TEMP_OUT_W = 12;
    localparam int HUM_OUT_W  = 10;

    // Temperature: (t - 4000) / 10, truncated toward zero.
    localparam int                    TEMP_D_W    = TEMP_RAW_W + 1;
    localparam logic [TEMP_D_W-1:0]   TEMP_OFFSET = TEMP_D_W'(4000);
    // |d| / 10 as (|d| * 52429) >> 19, exact for |d| < 2^14.
    localparam int                    DIV10_W     = 16;
    localparam int                    DIV10_SH    = 19;
    localparam logic [DIV10_W-1:0]    DIV10_MUL   = DIV10_W'(52429);
    localparam int                    TEMP_PROD_W = TEMP_RAW_W + DIV10_W;
    localparam int                    TEMP_MAG_W  = TEMP_PROD_W - DIV10_SH;

    // Humidity polynomial terms.
    localparam int                    HUM_A_W     = TEMP_RAW_W + 1;
    localparam int                    HUM_B_W     = HUM_RAW_W + 1;
    localparam logic [HUM_A_W-1:0]    HUM_T_OFS   = HUM_A_W'(6500);
    localparam logic [HUM_B_W-1:0]    HUM_H_OFS   = HUM_B_W'(125);
    localparam int                    P1_W        = HUM_A_W + HUM_B_W + 1;
    localparam int                    P2_W        = 2 * HUM_RAW_W;
    localparam int                    LIN_W       = 19;
    localparam logic [LIN_W-1:0]      HUM_LIN     = LIN_W'(405000);
    localparam int                    P3_W        = HUM_RAW_W + LIN_W;
    localparam int                    N_W         = 34;
    localparam logic signed [N_W-1:0] HUM_BIAS    = N_W'(40000000);
    localparam logic signed [N_W-1:0] N_UPPER     = N_W'(1000000000);
    localparam logic signed [N_W-1:0] N_LOWER     = N_W'(1000000);

    // floor(N / 10^6) = floor((N >> 6) / 15625); /15625 as (*C) >> 39.
    localparam int                    M_SH        = 6;
    localparam int                    M_W         = 24;
    localparam int                    RCP_W       = 26;
    localparam int                    RCP_SH      = 39;
    localparam logic [RCP_W-1:0]      RCP_MUL     = RCP_W'(35184373);
    localparam int                    Q_PROD_W    = M_W + RCP_W;

    localparam logic [HUM_OUT_W-1:0]  HUM_MAX     = HUM_OUT_W'(1000);
    localparam logic [HUM_OUT_W-1:0]  HUM_MIN     = HUM_OUT_W'(1);

    typedef logic signed [TEMP_OUT_W-1:0] t_temp;
    typedef logic [HUM_OUT_W-1:0]         t_hum;

endpackage

// ===== rtl/htc_if.sv =====
// Valid/ready channel interfaces for raw readings and compensated results.
// Depends on htc_pkg for field widths.
interface htc_in_if
    import htc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [TEMP_RAW_W-1:0] raw_temperature;
    logic [HUM_RAW_W-1:0]  raw_humidity;
    logic                  sensor_error;

    modport source (output valid, output raw_temperature, output raw_humidity,
                    output sensor_error, input ready);
    modport sink   (input valid, input raw_temperature, input raw_humidity,
                    input sensor_error, output ready);
endinterface

interface htc_out_if
    import htc_pkg::*;
();
    logic  valid;
    logic  ready;
    t_temp temperature_tenths;
    t_hum  humidity_tenths;

    modport source (output valid, output temperature_tenths, output humidity_tenths,
                    input ready);
    modport sink   (input valid, input temperature_tenths, input humidity_tenths,
                    output ready);
endinterface

// ===== rtl/humidity_temp_compensation.sv =====
// Throughput: one beat per cycle while the output is not back-pressured.
// Six register stages, each with its own valid bit; a stage loads whenever it is
// empty or the stage after it moves, so bubbles collapse under output backpressure.
// Widest step: 24x26 reciprocal multiply for /10^6 in stage 5.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits only.
// Depends on htc_pkg and the channel interfaces in htc_if.sv.
module humidity_temp_compensation
    import htc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    htc_in_if.sink    i_in,
    htc_out_if.source o_out
);

    // ---------------------------------------------------------------------
    // Stage enables: a stage loads if it is empty or its successor loads.
    // ---------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || o_out.ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: offsets. d = t - 4000 for temperature, a = t - 6500 and
    // b = h + 125 for the humidity temperature term.
    // ---------------------------------------------------------------------
    logic signed [TEMP_D_W-1:0] r_d1;
    logic signed [HUM_A_W-1:0]  r_a1;
    logic [HUM_B_W-1:0]         r_b1;
    logic [HUM_RAW_W-1:0]       r_h1;
    logic                       r_err1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_d1   <= $signed({1'b0, i_in.raw_temperature} - TEMP_OFFSET);
            r_a1   <= $signed({1'b0, i_in.raw_temperature} - HUM_T_OFS);
            r_b1   <= {1'b0, i_in.raw_humidity} + HUM_H_OFS;
            r_h1   <= i_in.raw_humidity;
            r_err1 <= i_in.sensor_error;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: the multiplies. p1 = a*b, p2 = h^2, p3 = 405000*h, and the
    // temperature magnitude times the /10 reciprocal.
    // ---------------------------------------------------------------------
    logic [TEMP_RAW_W-1:0]     n_dmag;
    logic signed [P1_W-1:0]    r_p1;
    logic [P2_W-1:0]           r_p2;
    logic [P3_W-1:0]           r_p3;
    logic [TEMP_PROD_W-1:0]    r_tq2;
    logic                      r_tneg2;
    logic                      r_err2;

    // |d| never exceeds 12383, so the low bits hold it exactly
    assign n_dmag = r_d1[TEMP_D_W-1] ? TEMP_RAW_W'(-r_d1) : r_d1[TEMP_RAW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p1    <= P1_W'(r_a1) * P1_W'($signed({1'b0, r_b1}));
            r_p2    <= P2_W'(r_h1) * P2_W'(r_h1);
            r_p3    <= P3_W'(r_h1) * P3_W'(HUM_LIN);
            r_tq2   <= TEMP_PROD_W'(n_dmag) * TEMP_PROD_W'(DIV10_MUL);
            r_tneg2 <= r_d1[TEMP_D_W-1];
            r_err2  <= r_err1;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: partial sums 8*p1 - 28*p2 and p3 - 4e7; temperature sign.
    // ---------------------------------------------------------------------
    logic [TEMP_MAG_W-1:0]    n_tmag;
    logic signed [N_W-1:0]    n_p2x;
    logic signed [N_W-1:0]    r_s1;
    logic signed [N_W-1:0]    r_s2;
    t_temp                    r_temp3;
    logic                     r_err3;

    assign n_tmag = r_tq2[TEMP_PROD_W-1:DIV10_SH];
    assign n_p2x  = $signed(N_W'(r_p2));

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s1    <= (N_W'(r_p1) <<< 3) - ((n_p2x <<< 5) - (n_p2x <<< 2));
            r_s2    <= $signed(N_W'(r_p3)) - HUM_BIAS;
            r_temp3 <= r_tneg2 ? -$signed(TEMP_OUT_W'(n_tmag))
                               :  $signed(TEMP_OUT_W'(n_tmag));
            r_err3  <= r_err2;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: N = s1 + s2.
    // ---------------------------------------------------------------------
    logic signed [N_W-1:0] r_n4;
    t_temp                 r_temp4;
    logic                  r_err4;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_n4    <= r_s1 + r_s2;
            r_temp4 <= r_temp3;
            r_err4  <= r_err3;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: clamp compares and the /10^6 reciprocal multiply. N >> 6 is
    // only meaningful inside the clamp window, where N < 2^30.
    // ---------------------------------------------------------------------
    logic [M_W-1:0]      n_m;
    logic [Q_PROD_W-1:0] r_q5;
    logic                r_hi5;
    logic                r_lo5;
    t_temp               r_temp5;
    logic                r_err5;

    assign n_m = r_n4[M_W+M_SH-1:M_SH];

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_q5    <= Q_PROD_W'(n_m) * Q_PROD_W'(RCP_MUL);
            r_hi5   <= r_n4 > N_UPPER;
            r_lo5   <= r_n4 < N_LOWER;
            r_temp5 <= r_temp4;
            r_err5  <= r_err4;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: output register. Clamp select, sensor error forces zeros.
    // ---------------------------------------------------------------------
    t_hum  n_hum;
    t_temp r_temp6;
    t_hum  r_hum6;
    logic  r_err6;

    always_comb begin
        if (r_hi5) begin
            n_hum = HUM_MAX;
        end else if (r_lo5) begin
            n_hum = HUM_MIN;
        end else begin
            n_hum = r_q5[RCP_SH+HUM_OUT_W-1:RCP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r_temp6 <= r_err5 ? '0 : r_temp5;
            r_hum6  <= r_err5 ? '0 : n_hum;
            r_err6  <= r_err5;
        end
    end

    assign o_out.valid              = r_v6;
    assign o_out.temperature_tenths = r_temp6;
    assign o_out.humidity_tenths    = r_hum6;

`ifndef ASSERT_OFF
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |-> (r_hum6 <= HUM_MAX))
        else $error("humidity result above 1000");

    a_hum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !r_err6) |-> (r_hum6 != '0))
        else $error("good reading gave zero humidity");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(i_in.valid))
        else $error("stage 1 filled without an input beat");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !o_out.ready && r_v5) |=> r_v5)
        else $error("stage 5 beat dropped during output stall");
`endif

endmodule
